### rtl/core/assert_macros.svh
// assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/core/pate_pkg.sv
// package with command codes, status codes and request/result types
package pate_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND     = 3'd0,
    MODE_UNIQUE     = 3'd1,
    MODE_DEL_VALUE  = 3'd2,
    MODE_DEL_INDEX  = 3'd3,
    MODE_SET        = 3'd4,
    MODE_GET        = 3'd5,
    MODE_CLEAR      = 3'd6,
    MODE_DEDUPE     = 3'd7
  } pate_mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_PRESENT = 2'd3
  } pate_status_t;

  typedef struct packed {
    pate_mode_t  mode;
    logic [31:0] value;
    logic [7:0]  index;
  } pate_in_t;

  typedef struct packed {
    logic [7:0]   result_index;
    logic [31:0]  result_value;
    logic [8:0]   fill_count;
    pate_status_t status;
  } pate_out_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic hit;
    logic more;
  } pate_cmp_t;

endpackage

### rtl/core/pate_store.sv
// element store: one write port, one registered read port
module pate_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/pate_cmp.sv
// shared compare unit: key match on read data and walk bound check
module pate_cmp #(
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 9
) (
  input  logic [VALUE_BITS-1:0] key,
  input  logic [VALUE_BITS-1:0] data,
  input  logic [CNT_W-1:0]      ptr,
  input  logic [CNT_W-1:0]      lim,
  output pate_pkg::pate_cmp_t   flags
);
  import pate_pkg::*;

  // one equality compare and one magnitude compare per cycle
  always_comb begin
    flags.hit  = (key == data);
    flags.more = (ptr < lim);
  end

endmodule

### rtl/core/pointer_array_table_engine.sv
// top level: fixed-capacity word table with search, compaction and dedupe
//
// A request is taken at a rising edge with start high and busy low; its
// fields arrive on in_item. Every request gives exactly one result on
// out_item, marked by out_valid for a single cycle; the receiver cannot
// hold it off. busy stays high while a request is still at work.
// Append, clear, full append and any bad-index case answer straight
// from idle; get and set read the store, then give the result; append
// unique walks the table up to a match, full or not; delete value walks
// it all; delete index walks from the index to the end; dedupe does one
// walk per kept element. The next request can be taken at the edge that
// ends the previous result cycle, so requests answered from idle run
// back to back. The walks stream one element per cycle through the
// store's single read port and the shared compare unit; compaction
// writes trail the reads. After reset the store is swept to zero, one
// entry per cycle; busy stays high and no request is taken until the
// sweep ends.
module pointer_array_table_engine #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pate_pkg::pate_in_t in_item,
  output logic               out_valid,
  output pate_pkg::pate_out_t out_item
);
  import pate_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_KEY,
    S_STREAM
  } state_t;

  state_t                  state_r, state_nxt;
  pate_mode_t              op_r, op_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CNT_W-1:0]        rp_r, rp_nxt;
  logic [CNT_W-1:0]        wr_r, wr_nxt;
  logic [CNT_W-1:0]        ko_r, ko_nxt;
  logic                    dv_r, dv_nxt;
  logic [AW-1:0]           di_r, di_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [VALUE_BITS-1:0]   key_r, key_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pate_out_t               out_r, out_nxt;

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [VALUE_BITS-1:0]   wdata, rd_data;
  pate_cmp_t               cmp;

  logic [VALUE_BITS-1:0]   in_v;
  logic [AW-1:0]           in_addr;
  logic [CMP_W-1:0]        idx_c, cnt_c, cap_c;
  logic [CNT_W-1:0]        cnt_inc, cnt_dec, ko_inc, set_cnt;

  function automatic pate_out_t mk_rsp(input logic [CNT_W-1:0]      pos,
                                       input logic [VALUE_BITS-1:0] val,
                                       input logic [CNT_W-1:0]      cnt,
                                       input pate_status_t          st);
    pate_out_t r;
    r.result_index = 8'(pos);
    r.result_value = 32'(val);
    r.fill_count   = 9'(cnt);
    r.status       = st;
    return r;
  endfunction

  pate_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  pate_cmp #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_cmp (
    .key   (key_r),
    .data  (rd_data),
    .ptr   (rp_r),
    .lim   (cnt_r),
    .flags (cmp)
  );

  // request field views at internal widths
  assign in_v    = VALUE_BITS'(in_item.value);
  assign in_addr = AW'(in_item.index);
  assign idx_c   = CMP_W'(in_item.index);
  assign cnt_c   = CMP_W'(cnt_r);
  assign cap_c   = CMP_W'(CAPACITY);
  assign cnt_inc = cnt_r + 1'b1;
  assign cnt_dec = cnt_r - 1'b1;
  assign ko_inc  = ko_r + 1'b1;
  assign set_cnt = (cnt_r <= CNT_W'(idx_r)) ? (CNT_W'(idx_r) + 1'b1) : cnt_r;

  // sequencer next-state and store control
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    rp_nxt        = rp_r;
    wr_nxt        = wr_r;
    ko_nxt        = ko_r;
    dv_nxt        = 1'b0;
    di_nxt        = di_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;

    unique case (state_r)
      S_CLEAR: begin
        // zero sweep after reset
        we     = 1'b1;
        waddr  = AW'(rp_r);
        rp_nxt = rp_r + 1'b1;
        if (rp_r == CNT_W'(CAPACITY - 1)) begin
          rp_nxt    = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt = in_item.mode;
          unique case (in_item.mode)
            MODE_APPEND: begin
              out_valid_nxt = 1'b1;
              if (cnt_c >= cap_c) begin
                out_nxt = mk_rsp('0, '0, cnt_r, ST_FULL);
              end else begin
                we      = 1'b1;
                waddr   = AW'(cnt_r);
                wdata   = in_v;
                cnt_nxt = cnt_inc;
                out_nxt = mk_rsp(cnt_r, '0, cnt_inc, ST_OK);
              end
            end
            MODE_UNIQUE, MODE_DEL_VALUE: begin
              key_nxt   = in_v;
              rp_nxt    = '0;
              wr_nxt    = '0;
              state_nxt = S_STREAM;
            end
            MODE_DEL_INDEX: begin
              if (idx_c >= cnt_c) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_rsp('0, '0, cnt_r, ST_RANGE);
              end else begin
                rp_nxt    = CNT_W'(in_item.index);
                idx_nxt   = in_addr;
                state_nxt = S_STREAM;
              end
            end
            MODE_SET: begin
              if (idx_c >= cap_c) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_rsp('0, '0, cnt_r, ST_RANGE);
              end else begin
                re        = 1'b1;
                raddr     = in_addr;
                idx_nxt   = in_addr;
                key_nxt   = in_v;
                state_nxt = S_RD;
              end
            end
            MODE_GET: begin
              if (idx_c >= cnt_c) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_rsp('0, '0, cnt_r, ST_RANGE);
              end else begin
                re        = 1'b1;
                raddr     = in_addr;
                idx_nxt   = in_addr;
                state_nxt = S_RD;
              end
            end
            MODE_CLEAR: begin
              cnt_nxt       = '0;
              out_valid_nxt = 1'b1;
              out_nxt       = mk_rsp('0, '0, '0, ST_OK);
            end
            MODE_DEDUPE: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_rsp('0, '0, '0, ST_OK);
              end else begin
                re        = 1'b1;
                raddr     = '0;
                ko_nxt    = '0;
                state_nxt = S_KEY;
              end
            end
          endcase
        end
      end

      S_RD: begin
        // read data for get or set is on the port now
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (op_r == MODE_SET) begin
          we      = 1'b1;
          waddr   = idx_r;
          wdata   = key_r;
          cnt_nxt = set_cnt;
          out_nxt = mk_rsp(CNT_W'(idx_r), rd_data, set_cnt, ST_OK);
        end else begin
          out_nxt = mk_rsp(CNT_W'(idx_r), rd_data, cnt_r, ST_OK);
        end
      end

      S_KEY: begin
        // dedupe key arrives, walk the tail behind it
        key_nxt   = rd_data;
        rp_nxt    = ko_inc;
        wr_nxt    = ko_inc;
        state_nxt = S_STREAM;
      end

      S_STREAM: begin
        // issue the next read of the walk
        if (cmp.more) begin
          re     = 1'b1;
          raddr  = AW'(rp_r);
          rp_nxt = rp_r + 1'b1;
          dv_nxt = 1'b1;
          di_nxt = AW'(rp_r);
        end
        if (dv_r) begin
          // handle the element read in the previous cycle
          case (op_r) inside
            MODE_UNIQUE: begin
              if (cmp.hit) begin
                dv_nxt        = 1'b0;
                out_valid_nxt = 1'b1;
                out_nxt       = mk_rsp(CNT_W'(di_r), '0, cnt_r, ST_PRESENT);
                state_nxt     = S_IDLE;
              end
            end
            MODE_DEL_VALUE, MODE_DEDUPE: begin
              if (!cmp.hit) begin
                we     = 1'b1;
                waddr  = AW'(wr_r);
                wdata  = rd_data;
                wr_nxt = wr_r + 1'b1;
              end
            end
            MODE_DEL_INDEX: begin
              if (di_r == idx_r) begin
                key_nxt = rd_data;
              end else begin
                we    = 1'b1;
                waddr = di_r - 1'b1;
                wdata = rd_data;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else if (!cmp.more) begin
          // walk done: close out the command, or for dedupe start the next key's walk
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (op_r) inside
            MODE_UNIQUE: begin
              if (cnt_c >= cap_c) begin
                out_nxt = mk_rsp('0, '0, cnt_r, ST_FULL);
              end else begin
                we      = 1'b1;
                waddr   = AW'(cnt_r);
                wdata   = key_r;
                cnt_nxt = cnt_inc;
                out_nxt = mk_rsp(cnt_r, '0, cnt_inc, ST_OK);
              end
            end
            MODE_DEL_VALUE: begin
              cnt_nxt = wr_r;
              out_nxt = mk_rsp('0, '0, wr_r, ST_OK);
            end
            MODE_DEL_INDEX: begin
              cnt_nxt = cnt_dec;
              out_nxt = mk_rsp(CNT_W'(idx_r), key_r, cnt_dec, ST_OK);
            end
            MODE_DEDUPE: begin
              cnt_nxt = wr_r;
              if (ko_inc < wr_r) begin
                // next kept element becomes the key
                re            = 1'b1;
                raddr         = AW'(ko_inc);
                ko_nxt        = ko_inc;
                out_valid_nxt = 1'b0;
                state_nxt     = S_KEY;
              end else begin
                out_nxt = mk_rsp('0, '0, wr_r, ST_OK);
              end
            end
            default: begin
              out_nxt = mk_rsp('0, '0, cnt_r, ST_OK);
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rp_r        <= '0;
      wr_r        <= '0;
      ko_r        <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= MODE_APPEND;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      wr_r        <= wr_nxt;
      ko_r        <= ko_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
    di_r  <= di_nxt;
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### rtl/core/pate_checker.sv
// port-level checker for the table engine, with its bind
`include "assert_macros.svh"

module pate_checker #(
  parameter int CAPACITY = 256
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input pate_pkg::pate_in_t  in_item,
  input logic                out_valid,
  input pate_pkg::pate_out_t out_item
);
  import pate_pkg::*;

  // a result only follows a taken request or ongoing work
  `ASSERT_SAME(a_no_spurious, out_valid, $past(busy) || $past(start))

  // clear answers in the next cycle with an empty table
  `ASSERT_NEXT(a_clear_next, start && !busy && in_item.mode == MODE_CLEAR, out_valid && out_item.fill_count == 9'd0)

  // a full report means the count sits at capacity
  `ASSERT_SAME(a_full_count, out_valid && out_item.status == ST_FULL, out_item.fill_count == 9'(CAPACITY))

  // a bad index never carries a value
  `ASSERT_SAME(a_range_zero, out_valid && out_item.status == ST_RANGE, out_item.result_value == 32'd0)

endmodule

bind pointer_array_table_engine pate_checker #(.CAPACITY(CAPACITY)) u_pate_checker (.*);
